// ===== src/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

	localparam int FRAC_BITS_DEF = 15;

	// 2*pi in Q30
	localparam logic [32:0] TWO_PI_Q = 33'd6746518852;

	// Horner slots; the sine lane runs one slot fewer and idles in the last one
	localparam int HORNER_STEPS = 6;
	localparam int SIN_STEPS = 5;
	localparam logic [7:0] SIN_DIV [0:5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
	localparam logic [7:0] COS_DIV [0:5] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

	// corner offsets of the two triangles of a cell
	localparam logic CORNER_DI [0:5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam logic CORNER_DJ [0:5] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
	localparam logic [2:0] LAST_CORNER = 3'd5;

	typedef enum logic [1:0] {
		REG_STACK_COUNT   = 2'd0,
		REG_SECTOR_COUNT  = 2'd1,
		REG_SPHERE_RADIUS = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== src/uv_sphere_cell_tessellator_core.sv =====
`default_nettype none
// Throughput: one vertex word per cycle while the output is not stalled; the input takes
// the next cell in the cycle the sixth vertex of the current one issues.
// Vertices issue from a single port into a fully pipelined angle divider,
// two sine/cosine pipelines and the scaling stages.
// Reset: asynchronous, clears the valid flags and loads the register defaults.
module uv_sphere_cell_tessellator_core #(
	parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [1:0]   cfg_idx,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// stack_index [4:0], sector_index [10:5]
	input  wire logic [15:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, pos_z (17 each), color_r, color_g, color_b (15 each),
	// normal_x, normal_y, normal_z (16 each)
	output logic [143:0]      m_tdata,
	output logic              m_tlast
);

	localparam int DIV_STAGES = 5;
	localparam longint ONE_F = longint'(1) << FRAC_BITS;
	localparam longint SAT_HI = (ONE_F - 1 > 32767) ? 32767 : ONE_F - 1;
	localparam longint SAT_LO = (-ONE_F < -32768) ? -32768 : -ONE_F;
	localparam longint COL_RND = longint'(1) << (30 - FRAC_BITS);

	typedef struct packed {
		logic [6:0]  den;
		logic [6:0]  rem;
		logic [31:0] quo;
		logic [39:0] dvd;
	} div_t;

	typedef struct packed {
		logic last;
		logic valid;
	} vtag_t;

	function automatic div_t div8(input div_t a);
		logic [7:0] t;
		logic       b;
		div_t       r;
		r = a;
		for (int i = 0; i < 8; i++) begin
			t = {r.rem, r.dvd[39]};
			r.dvd = {r.dvd[38:0], 1'b0};
			b = t >= {1'b0, r.den};
			if (b) begin
				t = t - {1'b0, r.den};
			end
			r.rem = t[6:0];
			r.quo = {r.quo[30:0], b};
		end
		return r;
	endfunction

	function automatic longint shr_rnd(input longint v, input int sh);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) << (sh - 1))) >>> sh;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// configuration
	logic [5:0]  stack_cnt_q;
	logic [6:0]  sector_cnt_q;
	logic [15:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= 6'd18;
			sector_cnt_q <= 7'd36;
			radius_q <= 16'd16384;
		end else if (cfg_wen) begin
			case (cfg_idx)
				uvs_pkg::REG_STACK_COUNT:   stack_cnt_q <= cfg_wdata[5:0];
				uvs_pkg::REG_SECTOR_COUNT:  sector_cnt_q <= cfg_wdata[6:0];
				uvs_pkg::REG_SPHERE_RADIUS: radius_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advances when the output word is empty or taken
	logic en;
	assign en = !m_tvalid || m_tready;

	// cell expander: one corner per cycle while the pipeline advances
	logic       busy_q;
	logic [2:0] vtx_q;
	logic [4:0] si_q;
	logic [5:0] sj_q;
	logic       accept;

	assign s_tready = !busy_q || (vtx_q == uvs_pkg::LAST_CORNER && en);
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vtx_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			vtx_q <= '0;
		end else if (en && busy_q) begin
			if (vtx_q == uvs_pkg::LAST_CORNER) begin
				busy_q <= 1'b0;
			end else begin
				vtx_q <= vtx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			si_q <= s_tdata[4:0];
			sj_q <= s_tdata[10:5];
		end
	end

	logic [5:0] stacks_c, num_p_c;
	logic [6:0] den_p_c, den_t_c, num_t_c;
	div_t       dp_d [0:DIV_STAGES];
	div_t       dt_d [0:DIV_STAGES];
	vtag_t      vl_d [0:DIV_STAGES];

	always_comb begin
		stacks_c = (stack_cnt_q == '0) ? 6'd1 : stack_cnt_q;
		den_p_c = {stacks_c, 1'b0};
		den_t_c = (sector_cnt_q == '0) ? 7'd1 : sector_cnt_q;
		num_p_c = {1'b0, si_q} + {5'd0, uvs_pkg::CORNER_DI[vtx_q]};
		num_t_c = {1'b0, sj_q} + {6'd0, uvs_pkg::CORNER_DJ[vtx_q]};
		dp_d[0] = '{den: den_p_c, rem: '0, quo: '0,
			dvd: {2'b0, num_p_c, 26'd0, den_p_c[6:1]}};
		dt_d[0] = '{den: den_t_c, rem: '0, quo: '0,
			dvd: {1'b0, num_t_c, 26'd0, den_t_c[6:1]}};
		vl_d[0] = '{last: (vtx_q == uvs_pkg::LAST_CORNER), valid: busy_q};
	end

	// turn angle: rounded corner fraction, eight quotient bits per stage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_t  dp_s, dt_s;
		vtag_t vl_s;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s <= '0;
			end else if (en) begin
				vl_s <= vl_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dp_s <= div8(dp_d[k]);
				dt_s <= div8(dt_d[k]);
			end
		end

		assign dp_d[k+1] = dp_s;
		assign dt_d[k+1] = dt_s;
		assign vl_d[k+1] = vl_s;
	end

	logic signed [31:0] sp, cp, st, ct;
	vtag_t              vl_sc;
	logic               vt_sc;

	uvs_sincos #(.TAG_W(2)) u_phi (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.angle   (dp_d[DIV_STAGES].quo),
		.tag_in  (vl_d[DIV_STAGES]),
		.sin_val (sp),
		.cos_val (cp),
		.tag_out (vl_sc)
	);

	uvs_sincos #(.TAG_W(1)) u_theta (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.angle   (dt_d[DIV_STAGES].quo),
		.tag_in  (vl_d[DIV_STAGES].valid),
		.sin_val (st),
		.cos_val (ct),
		.tag_out (vt_sc)
	);

	// c1: spherical products
	logic signed [63:0] m0_c1, m2_c1;
	logic signed [31:0] cp_c1;
	vtag_t              vl_c1, vl_c2, vl_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_c1 <= '0;
			vl_c2 <= '0;
			vl_c3 <= '0;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
		end else if (en) begin
			vl_c1 <= '{last: vl_sc.last, valid: vl_sc.valid && vt_sc};
			vl_c2 <= vl_c1;
			vl_c3 <= vl_c2;
			m_tvalid <= vl_c3.valid;
			m_tlast <= vl_c3.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_c1 <= 64'(ct) * 64'(sp);
			m2_c1 <= 64'(st) * 64'(sp);
			cp_c1 <= cp;
		end
	end

	// c2: round back to Q30
	logic signed [31:0] u_c2 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			u_c2[0] <= 32'(shr_rnd(m0_c1, 30));
			u_c2[1] <= cp_c1;
			u_c2[2] <= 32'(shr_rnd(m2_c1, 30));
		end
	end

	// c3: scale by radius
	logic signed [48:0] pp_c3 [0:2];
	logic signed [31:0] u_c3  [0:2];

	for (genvar k = 0; k < 3; k++) begin : g_scale
		always_ff @(posedge clk) begin
			if (en) begin
				pp_c3[k] <= 49'($signed({1'b0, radius_q})) * 49'(u_c2[k]);
				u_c3[k] <= u_c2[k];
			end
		end
	end

	// c4: round, saturate, output word
	logic [16:0] pos_c4 [0:2];
	logic [14:0] col_c4 [0:2];
	logic [15:0] nrm_c4 [0:2];

	for (genvar k = 0; k < 3; k++) begin : g_out
		longint pos_c, col_c, nrm_c;

		always_comb begin
			pos_c = clamp(shr_rnd(64'(pp_c3[k]), 30), -65536, 65535);
			col_c = (longint'(1 << 30) + 64'(u_c3[k]) + COL_RND) >>> (31 - FRAC_BITS);
			col_c = clamp(col_c, 0, SAT_HI);
			nrm_c = clamp(shr_rnd(64'(u_c3[k]), 30 - FRAC_BITS), SAT_LO, SAT_HI);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pos_c4[k] <= pos_c[16:0];
				col_c4[k] <= col_c[14:0];
				nrm_c4[k] <= nrm_c[15:0];
			end
		end
	end

	assign m_tdata = {nrm_c4[2], nrm_c4[1], nrm_c4[0],
		col_c4[2], col_c4[1], col_c4[0],
		pos_c4[2], pos_c4[1], pos_c4[0]};

endmodule
`default_nettype wire

// ===== src/uvs_sincos.sv =====
`default_nettype none
module uvs_sincos #(
	parameter int TAG_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [31:0]       angle,
	input  wire logic [TAG_W-1:0]  tag_in,
	output logic signed [31:0]     sin_val,
	output logic signed [31:0]     cos_val,
	output logic [TAG_W-1:0]       tag_out
);

	typedef struct packed {
		logic [29:0] x;
		logic [29:0] x2;
		logic [1:0]  quad;
		logic        fold;
	} ctx_t;

	localparam logic [30:0] ONE_Q = 31'h4000_0000;
	localparam int NS = uvs_pkg::HORNER_STEPS;

	// stage 1: fold into first octant
	logic [29:0] r_c, rr_c, rr_s1;
	logic        fold_c, fold_s1;
	logic [1:0]  quad_s1;
	logic [TAG_W-1:0] tag_s1;

	always_comb begin
		r_c = angle[29:0];
		fold_c = r_c > 30'h2000_0000;
		rr_c = fold_c ? 30'(ONE_Q - {1'b0, r_c}) : r_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1 <= rr_c;
			fold_s1 <= fold_c;
			quad_s1 <= angle[31:30];
		end
	end

	// stage 2: turn fraction to radians
	logic [63:0] xprod_c;
	logic [29:0] x_s2;
	logic        fold_s2;
	logic [1:0]  quad_s2;
	logic [TAG_W-1:0] tag_s2;

	assign xprod_c = {34'd0, rr_s1} * {31'd0, uvs_pkg::TWO_PI_Q} + 64'h8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xprod_c[61:32];
			fold_s2 <= fold_s1;
			quad_s2 <= quad_s1;
		end
	end

	// stage 3: square
	logic [60:0] x2prod_c;
	ctx_t        ctx_s3;
	logic [TAG_W-1:0] tag_s3;

	assign x2prod_c = {31'd0, x_s2} * {31'd0, x_s2} + 61'h2000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3.x <= x_s2;
			ctx_s3.x2 <= x2prod_c[59:30];
			ctx_s3.quad <= quad_s2;
			ctx_s3.fold <= fold_s2;
		end
	end

	// Horner steps, three stages each: multiply, reciprocal multiply, correct
	logic [30:0]      ts_a  [0:NS];
	logic [30:0]      tc_a  [0:NS];
	ctx_t             ctx_a [0:NS];
	logic [TAG_W-1:0] tag_a [0:NS];

	assign ts_a[0] = ONE_Q;
	assign tc_a[0] = ONE_Q;
	assign ctx_a[0] = ctx_s3;
	assign tag_a[0] = tag_s3;

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam bit SIN_ON = (k < uvs_pkg::SIN_STEPS);
		localparam logic [7:0] DS = uvs_pkg::SIN_DIV[k];
		localparam logic [7:0] DC = uvs_pkg::COS_DIV[k];
		localparam logic [30:0] MS = 31'((64'd1 << 31) / DS);
		localparam logic [30:0] MC = 31'((64'd1 << 31) / DC);

		logic [60:0] pps_c, ppc_c, qps_c, qpc_c;
		logic [29:0] ps_sa, pc_sa, ps_sb, pc_sb, q0s_sb, q0c_sb;
		logic [30:0] ts_sa, ts_sb, ts_sc, tc_sc;
		ctx_t        ctx_sa, ctx_sb, ctx_sc;
		logic [TAG_W-1:0] tag_sa, tag_sb, tag_sc;
		logic [29:0] rs_c, rc_c, qs_c, qc_c;

		assign pps_c = {30'd0, ctx_a[k].x2} * {30'd0, ts_a[k]};
		assign ppc_c = {30'd0, ctx_a[k].x2} * {30'd0, tc_a[k]};
		assign qps_c = {31'd0, ps_sa} * {30'd0, MS};
		assign qpc_c = {31'd0, pc_sa} * {30'd0, MC};

		always_comb begin
			rs_c = ps_sb - 30'(q0s_sb * DS);
			rc_c = pc_sb - 30'(q0c_sb * DC);
			qs_c = (rs_c >= {22'd0, DS}) ? q0s_sb + 30'd1 : q0s_sb;
			qc_c = (rc_c >= {22'd0, DC}) ? q0c_sb + 30'd1 : q0c_sb;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sa <= '0;
				tag_sb <= '0;
				tag_sc <= '0;
			end else if (en) begin
				tag_sa <= tag_a[k];
				tag_sb <= tag_sa;
				tag_sc <= tag_sb;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ps_sa <= pps_c[59:30];
				pc_sa <= ppc_c[59:30];
				ts_sa <= ts_a[k];
				ctx_sa <= ctx_a[k];
				ps_sb <= ps_sa;
				pc_sb <= pc_sa;
				q0s_sb <= qps_c[60:31];
				q0c_sb <= qpc_c[60:31];
				ts_sb <= ts_sa;
				ctx_sb <= ctx_sa;
				ts_sc <= SIN_ON ? ONE_Q - {1'b0, qs_c} : ts_sb;
				tc_sc <= ONE_Q - {1'b0, qc_c};
				ctx_sc <= ctx_sb;
			end
		end

		assign ts_a[k+1] = ts_sc;
		assign tc_a[k+1] = tc_sc;
		assign ctx_a[k+1] = ctx_sc;
		assign tag_a[k+1] = tag_sc;
	end

	// final multiply by x for the sine
	logic [60:0] snp_c;
	logic [29:0] sn_f1;
	logic [30:0] cs_f1;
	logic [1:0]  quad_f1;
	logic        fold_f1;
	logic [TAG_W-1:0] tag_f1;

	assign snp_c = {31'd0, ctx_a[NS].x} * {30'd0, ts_a[NS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_f1 <= '0;
			tag_out <= '0;
		end else if (en) begin
			tag_f1 <= tag_a[NS];
			tag_out <= tag_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_f1 <= snp_c[59:30];
			cs_f1 <= tc_a[NS];
			quad_f1 <= ctx_a[NS].quad;
			fold_f1 <= ctx_a[NS].fold;
		end
	end

	// unfold octant and quadrant
	logic signed [31:0] as_c, ac_c, s_c, c_c;

	always_comb begin
		as_c = fold_f1 ? $signed({1'b0, cs_f1}) : $signed({2'b0, sn_f1});
		ac_c = fold_f1 ? $signed({2'b0, sn_f1}) : $signed({1'b0, cs_f1});
		case (quad_f1)
			2'd0: begin
				s_c = as_c;
				c_c = ac_c;
			end
			2'd1: begin
				s_c = ac_c;
				c_c = -as_c;
			end
			2'd2: begin
				s_c = -as_c;
				c_c = -ac_c;
			end
			default: begin
				s_c = -ac_c;
				c_c = as_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= s_c;
			cos_val <= c_c;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_uv_sphere_cell_tessellator_core.sv =====
`timescale 1ns / 100ps
module tb_uv_sphere_cell_tessellator_core;

	localparam int FB = 15;
	localparam longint unsigned ONE_Q = 64'd1 << 30;
	localparam longint unsigned TWO_PI = 64'd6746518852;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [143:0] data;
		logic         last;
	} vertex_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [1:0]   cfg_idx;
	logic [15:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic         m_tlast;

	uv_sphere_cell_tessellator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// field offsets and widths inside a vertex word, lowest first
	int fld_off [0:8] = '{0, 17, 34, 51, 66, 81, 96, 112, 128};
	int fld_w   [0:8] = '{17, 17, 17, 15, 15, 15, 16, 16, 16};

	vertex_t     pending_vertices[$];
	logic [5:0]  mdl_stacks;
	logic [6:0]  mdl_sectors;
	logic [15:0] mdl_radius;
	int          errors;
	bit          idle_en;
	int          hold_reqs, hold_seen, hold_left;
	int          quiet_cycles;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned turn_angle(longint unsigned num, longint unsigned den);
		if (den == 0)
			den = 1;
		return (((num << 32) + den / 2) / den) & 64'hFFFF_FFFF;
	endfunction

	function automatic void sin_cos(input longint unsigned a, output longint s, output longint c);
		longint unsigned quad, r, x, x2, t, sn, cs, tmp;
		bit fold;
		quad = (a >> 30) & 3;
		r = a & 64'h3FFF_FFFF;
		fold = r > (64'd1 << 29);
		if (fold)
			r = (64'd1 << 30) - r;
		x = (r * TWO_PI + (64'd1 << 31)) >> 32;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		t = ONE_Q;
		for (int k = 0; k < uvs_pkg::SIN_STEPS; k++)
			t = ONE_Q - ((x2 * t) >> 30) / uvs_pkg::SIN_DIV[k];
		sn = (x * t) >> 30;
		t = ONE_Q;
		for (int k = 0; k < uvs_pkg::HORNER_STEPS; k++)
			t = ONE_Q - ((x2 * t) >> 30) / uvs_pkg::COS_DIV[k];
		cs = t;
		if (fold) begin
			tmp = sn;
			sn = cs;
			cs = tmp;
		end
		case (quad)
			0: begin s = sn; c = cs; end
			1: begin s = cs; c = -longint'(cs - cs + sn); end
			2: begin s = -longint'(sn); c = -longint'(cs); end
			default: begin s = -longint'(cs); c = sn; end
		endcase
	endfunction

	function automatic longint round_shift(longint v, int sh);
		longint unsigned m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// six vertices of the cell, queued in issue order
	function automatic void predict_cell(logic [4:0] si, logic [5:0] sj);
		longint unsigned stacks, sectors;
		longint sp, cp, st, ct, pos, col, nrm;
		longint u [3];
		vertex_t vx;
		stacks = mdl_stacks == 0 ? 1 : mdl_stacks;
		sectors = mdl_sectors == 0 ? 1 : mdl_sectors;
		for (int v = 0; v < 6; v++) begin
			sin_cos(turn_angle(si + uvs_pkg::CORNER_DI[v], 2 * stacks), sp, cp);
			sin_cos(turn_angle(sj + uvs_pkg::CORNER_DJ[v], sectors), st, ct);
			u[0] = round_shift(ct * sp, 30);
			u[1] = cp;
			u[2] = round_shift(st * sp, 30);
			vx.data = '0;
			for (int k = 0; k < 3; k++) begin
				pos = clamp(round_shift(longint'(mdl_radius) * u[k], 30), -65536, 65535);
				col = (longint'(ONE_Q) + u[k] + (64'sd1 << (30 - FB))) >>> (31 - FB);
				col = clamp(col, 0, (1 << FB) - 1);
				nrm = clamp(round_shift(u[k], 30 - FB), -(1 << FB), (1 << FB) - 1);
				nrm = clamp(nrm, -32768, 32767);
				vx.data[17*k +: 17] = pos[16:0];
				vx.data[51 + 15*k +: 15] = col[14:0];
				vx.data[96 + 16*k +: 16] = nrm[15:0];
			end
			vx.last = (v == uvs_pkg::LAST_CORNER);
			pending_vertices = {pending_vertices, vx};
		end
	endfunction

	// receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= !(idle_en && $urandom_range(99) < 36);
	end

	always @(posedge clk) begin
		vertex_t want;
		logic [143:0] fmask;
		if (m_tvalid && m_tready) begin
			if (pending_vertices.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected vertex word %h last %b", m_tdata, m_tlast);
			end else begin
				want = pending_vertices.pop_front();
				for (int f = 0; f < 9; f++) begin
					fmask = (144'd1 << fld_w[f]) - 1;
					if (((m_tdata >> fld_off[f]) & fmask) != ((want.data >> fld_off[f]) & fmask)) begin
						errors++;
						if (errors <= 10)
							$display("field %0d: expected %h actual %h", f,
								(want.data >> fld_off[f]) & fmask, (m_tdata >> fld_off[f]) & fmask);
					end
				end
				if (m_tlast !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("last: expected %b actual %b", want.last, m_tlast);
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_cell(input logic [4:0] si, input logic [5:0] sj);
		int gap;
		gap = (idle_en && $urandom_range(99) < 36) ? $urandom_range(4, 1) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, sj, si};
		do @(posedge clk); while (!s_tready);
		predict_cell(si, sj);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input uvs_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			uvs_pkg::REG_STACK_COUNT:   mdl_stacks = val[5:0];
			uvs_pkg::REG_SECTOR_COUNT:  mdl_sectors = val[6:0];
			default:                    mdl_radius = val;
		endcase
	endtask

	task automatic set_sphere(input logic [15:0] st, input logic [15:0] se, input logic [15:0] rad);
		wait_drained();
		write_reg(uvs_pkg::REG_STACK_COUNT, st);
		write_reg(uvs_pkg::REG_SECTOR_COUNT, se);
		write_reg(uvs_pkg::REG_SPHERE_RADIUS, rad);
	endtask

	task automatic test_defaults();
		send_cell(5'd0, 6'd0);
		send_cell(5'd17, 6'd35);
		send_cell(5'd9, 6'd18);
		send_cell(5'd31, 6'd63);
	endtask

	task automatic test_extreme_counts();
		set_sphere(16'd1, 16'd1, 16'd65535);
		send_cell(5'd0, 6'd0);
		send_cell(5'd1, 6'd1);
		// zero counts act as one
		set_sphere(16'd0, 16'd0, 16'd0);
		send_cell(5'd0, 6'd0);
		send_cell(5'd31, 6'd63);
		set_sphere(16'd32, 16'd64, 16'd32768);
		send_cell(5'd0, 6'd0);
		send_cell(5'd8, 6'd16);
		send_cell(5'd16, 6'd32);
		send_cell(5'd24, 6'd48);
		send_cell(5'd31, 6'd63);
		// widest register values, upper bits dropped
		set_sphere(16'hFFFF, 16'hFFFF, 16'd65535);
		send_cell(5'd31, 6'd63);
		send_cell(5'd15, 6'd42);
	endtask

	task automatic test_backpressure();
		set_sphere(16'd18, 16'd36, 16'd40000);
		idle_en = 1'b0;
		hold_reqs++;
		repeat (40)
			send_cell(5'($urandom_range(17)), 6'($urandom_range(35)));
		idle_en = 1'b1;
	endtask

	task automatic test_random();
		int st, se;
		for (int p = 0; p < 8; p++) begin
			st = (p == 0) ? 32 : $urandom_range(32, 1);
			se = (p == 1) ? 64 : $urandom_range(64, 1);
			set_sphere(16'(st), 16'(se), (p == 2) ? 16'd65535 : 16'($urandom_range(65535)));
			// one phase runs without any idling
			idle_en = (p != 3);
			for (int n = 0; n < 53; n++) begin
				if ($urandom_range(99) < 85)
					send_cell(5'($urandom_range(st - 1)), 6'($urandom_range(se - 1)));
				else
					send_cell(5'($urandom_range(31)), 6'($urandom_range(63)));
			end
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		idle_en = 1'b1;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet_cycles = 0;
		mdl_stacks = 6'd18;
		mdl_sectors = 7'd36;
		mdl_radius = 16'd16384;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_extreme_counts();
		test_backpressure();
		test_random();
		wait_drained();

		errors += pending_vertices.size();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== uv_sphere_cell_tessellator_core.f =====
src/uvs_pkg.sv
src/uvs_sincos.sv
src/uv_sphere_cell_tessellator_core.sv
tb/tb_uv_sphere_cell_tessellator_core.sv
